// ===== hdl/terminal_id_query_interceptor_assert.svh =====
// Assertion macros shared by the checker.
// The clock is named clock and the synchronous reset is named reset.
`ifndef TERMINAL_ID_QUERY_INTERCEPTOR_ASSERT_SVH
`define TERMINAL_ID_QUERY_INTERCEPTOR_ASSERT_SVH

// Same-cycle implication, off during reset
`define TQI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset
`define TQI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks across reset
`define TQI_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/tqi_pkg.sv =====
`timescale 1ns / 1ps

package tqi_pkg;

   // Held escape prefix
   localparam int PREFIX_DEPTH = 16;
   localparam int PIDX_W       = $clog2(PREFIX_DEPTH);
   localparam int PCNT_W       = $clog2(PREFIX_DEPTH + 1);

   // Stream characters
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_Z        = 8'h5A;
   localparam logic [7:0] CH_C        = 8'h63;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] FINAL_LO    = 8'h40;
   localparam logic [7:0] FINAL_HI    = 8'h7E;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDENTITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd1;

   // Profile codes
   localparam logic [2:0] ID_IDENT_ONLY = 3'd0;
   localparam logic [2:0] ID_DEFAULT    = 3'd1;
   localparam logic [2:0] ID_PROF2      = 3'd2;
   localparam logic [2:0] ID_PROF3      = 3'd3;
   localparam logic [2:0] ID_PROF4      = 3'd4;

   // Reply ROM: all replies back to back
   localparam int ROM_DEPTH = 41;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam int LEN_W     = 5;

   localparam logic [ROM_AW-1:0] ROM_IDENT = 6'd0;
   localparam logic [ROM_AW-1:0] ROM_DA_A  = 6'd3;
   localparam logic [ROM_AW-1:0] ROM_DA_B  = 6'd10;
   localparam logic [ROM_AW-1:0] ROM_DA_C  = 6'd15;
   localparam logic [ROM_AW-1:0] ROM_DA_D  = 6'd34;

   localparam logic [LEN_W-1:0] LEN_IDENT = 5'd3;
   localparam logic [LEN_W-1:0] LEN_DA_A  = 5'd7;
   localparam logic [LEN_W-1:0] LEN_DA_B  = 5'd5;
   localparam logic [LEN_W-1:0] LEN_DA_C  = 5'd19;
   localparam logic [LEN_W-1:0] LEN_DA_D  = 5'd7;

   localparam logic [7:0] REPLY_ROM [ROM_DEPTH] = '{
      // identify reply
      8'h1B, 8'h2F, 8'h5A,
      // attributes reply, default profile
      8'h1B, 8'h5B, 8'h3F, 8'h31, 8'h3B, 8'h30, 8'h63,
      // attributes reply, profile 2
      8'h1B, 8'h5B, 8'h3F, 8'h36, 8'h63,
      // attributes reply, profile 3
      8'h1B, 8'h5B, 8'h3F, 8'h36, 8'h32, 8'h3B, 8'h31, 8'h3B, 8'h32, 8'h3B,
      8'h36, 8'h3B, 8'h38, 8'h3B, 8'h39, 8'h3B, 8'h31, 8'h35, 8'h63,
      // attributes reply, profile 4
      8'h1B, 8'h5B, 8'h3F, 8'h31, 8'h3B, 8'h32, 8'h63
   };

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_ESC,
      MODE_CSI,
      MODE_FLUSH
   } parse_mode_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_PASS,
      ACT_FLUSH,
      ACT_REPLY
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_REPLY
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic flush_step;
      logic reply_step;
   } tqi_cmd_type;

   // Datapath to controller
   typedef struct packed {
      action_type act;
      logic       out_free;
      logic       flush_last;
      logic       reply_last;
   } tqi_stat_type;

endpackage

// ===== hdl/tqi_dp.sv =====
`timescale 1ns / 1ps

module tqi_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  tqi_pkg::tqi_cmd_type           cmd,
   output tqi_pkg::tqi_stat_type          stat,
   input  logic [7:0]                     req_in_byte,
   input  logic                           req_first_of_call,
   input  logic                           csr_we,
   input  logic [tqi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_to_response,
   output logic                           rsp_last_of_run
);
   import tqi_pkg::*;

   // Configuration
   logic [2:0]  identity_ff;
   logic [15:0] capacity_ff;

   // Parser state
   parse_mode_type    mode_ff, mode_in;
   logic [7:0]        prefix_ff [PREFIX_DEPTH];
   logic [PCNT_W-1:0] count_ff, count_in;
   logic [15:0]       fill_ff, fill_in;

   // Run sequencing
   logic [7:0]        held_ff;
   logic [PCNT_W-1:0] flen_ff;
   logic [PCNT_W-1:0] fptr_ff;
   logic [ROM_AW-1:0] raddr_ff;
   logic [ROM_AW-1:0] rend_ff;

   // Output register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_resp_ff, out_resp_in;
   logic       out_last_ff, out_last_in;

   logic              is_param;
   logic              pwrite;
   logic [PIDX_W-1:0] pw_idx;
   action_type        act;
   logic [ROM_AW-1:0] rep_start;
   logic [LEN_W-1:0]  rep_len;
   logic [15:0]       fill_base;
   logic              reply_ok;
   logic              out_free;
   logic              load;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fill_base = req_first_of_call ? 16'd0 : fill_ff;
   assign is_param  = req_in_byte inside {[CH_ZERO:CH_NINE], CH_SEMI};

   // Reply lookup: identify after ESC, attributes inside CSI
   always_comb begin
      rep_start = ROM_IDENT;
      rep_len   = '0;
      if (mode_ff == MODE_ESC) begin
         if (identity_ff inside {ID_IDENT_ONLY, ID_DEFAULT, ID_PROF2}) begin
            rep_start = ROM_IDENT;
            rep_len   = LEN_IDENT;
         end
      end else begin
         case (identity_ff)
            ID_DEFAULT: begin
               rep_start = ROM_DA_A;
               rep_len   = LEN_DA_A;
            end
            ID_PROF2: begin
               rep_start = ROM_DA_B;
               rep_len   = LEN_DA_B;
            end
            ID_PROF3: begin
               rep_start = ROM_DA_C;
               rep_len   = LEN_DA_C;
            end
            ID_PROF4: begin
               rep_start = ROM_DA_D;
               rep_len   = LEN_DA_D;
            end
            default: begin
               rep_start = ROM_IDENT;
               rep_len   = '0;
            end
         endcase
      end
   end

   // Reply fits in what is left of the call's budget
   assign reply_ok = (rep_len != '0) &&
                     (({1'b0, fill_base} + 17'(rep_len)) <= {1'b0, capacity_ff});

   // Byte decode
   always_comb begin
      act      = ACT_NONE;
      mode_in  = mode_ff;
      count_in = count_ff;
      pwrite   = 1'b0;
      pw_idx   = count_ff[PIDX_W-1:0];
      case (mode_ff)
         MODE_NORMAL: begin
            if (req_in_byte == CH_ESC) begin
               pwrite   = 1'b1;
               pw_idx   = '0;
               count_in = PCNT_W'(1);
               mode_in  = MODE_ESC;
            end else begin
               act = ACT_PASS;
            end
         end
         MODE_ESC: begin
            if (req_in_byte == CH_LBRACKET) begin
               if (count_ff < PCNT_W'(PREFIX_DEPTH)) begin
                  pwrite   = 1'b1;
                  count_in = count_ff + PCNT_W'(1);
               end
               mode_in = MODE_CSI;
            end else if (req_in_byte == CH_Z) begin
               act      = reply_ok ? ACT_REPLY : ACT_NONE;
               count_in = '0;
               mode_in  = MODE_NORMAL;
            end else begin
               act      = ACT_FLUSH;
               count_in = '0;
               mode_in  = MODE_NORMAL;
            end
         end
         MODE_CSI: begin
            if (is_param) begin
               if (count_ff < PCNT_W'(PREFIX_DEPTH)) begin
                  pwrite   = 1'b1;
                  count_in = count_ff + PCNT_W'(1);
               end else begin
                  act      = ACT_FLUSH;
                  count_in = '0;
                  mode_in  = MODE_FLUSH;
               end
            end else if (req_in_byte == CH_C) begin
               act      = reply_ok ? ACT_REPLY : ACT_NONE;
               count_in = '0;
               mode_in  = MODE_NORMAL;
            end else begin
               act      = ACT_FLUSH;
               count_in = '0;
               mode_in  = MODE_NORMAL;
            end
         end
         default: begin
            // overflow pass-through until a final byte
            act = ACT_PASS;
            if (req_in_byte inside {[FINAL_LO:FINAL_HI]}) begin
               mode_in = MODE_NORMAL;
            end
         end
      endcase
   end

   // Reply count for this call
   assign fill_in = (act == ACT_REPLY) ? fill_base + 16'(rep_len) : fill_base;

   // Output register next value
   always_comb begin
      load        = 1'b0;
      out_byte_in = out_byte_ff;
      out_resp_in = out_resp_ff;
      out_last_in = out_last_ff;
      if (cmd.accept && act == ACT_PASS) begin
         load        = 1'b1;
         out_byte_in = req_in_byte;
         out_resp_in = 1'b0;
         out_last_in = 1'b1;
      end else if (cmd.flush_step) begin
         load        = 1'b1;
         out_byte_in = (fptr_ff < flen_ff) ? prefix_ff[fptr_ff[PIDX_W-1:0]] : held_ff;
         out_resp_in = 1'b0;
         out_last_in = stat.flush_last;
      end else if (cmd.reply_step) begin
         load        = 1'b1;
         out_byte_in = REPLY_ROM[raddr_ff];
         out_resp_in = 1'b1;
         out_last_in = stat.reply_last;
      end
      out_valid_in = load || (out_valid_ff && !rsp_ready);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         identity_ff  <= ID_DEFAULT;
         capacity_ff  <= 16'hFFFF;
         mode_ff      <= MODE_NORMAL;
         count_ff     <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_IDENTITY) begin
            identity_ff <= csr_data[2:0];
         end
         if (csr_we && csr_index == CSR_CAPACITY) begin
            capacity_ff <= csr_data;
         end
         if (cmd.accept) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            fill_ff  <= fill_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Prefix store and run pointers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (pwrite) begin
            prefix_ff[pw_idx] <= req_in_byte;
         end
         held_ff  <= req_in_byte;
         flen_ff  <= count_ff;
         fptr_ff  <= '0;
         raddr_ff <= rep_start;
         rend_ff  <= rep_start + ROM_AW'(rep_len) - ROM_AW'(1);
      end else begin
         if (cmd.flush_step) begin
            fptr_ff <= fptr_ff + PCNT_W'(1);
         end
         if (cmd.reply_step) begin
            raddr_ff <= raddr_ff + ROM_AW'(1);
         end
      end
      out_byte_ff <= out_byte_in;
      out_resp_ff <= out_resp_in;
      out_last_ff <= out_last_in;
   end

   // Status
   assign stat.act        = act;
   assign stat.out_free   = out_free;
   assign stat.flush_last = (fptr_ff == flen_ff);
   assign stat.reply_last = (raddr_ff == rend_ff);

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_to_response = out_resp_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

// ===== hdl/tqi_ctrl.sv =====
`timescale 1ns / 1ps

module tqi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tqi_pkg::tqi_stat_type stat,
   output tqi_pkg::tqi_cmd_type  cmd
);
   import tqi_pkg::*;

   ctrl_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.out_free) begin
               case (stat.act)
                  ACT_FLUSH: state_in = ST_FLUSH;
                  ACT_REPLY: state_in = ST_REPLY;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_FLUSH: begin
            if (stat.out_free && stat.flush_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (stat.out_free && stat.reply_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = stat.out_free;
            cmd.accept = req_valid && stat.out_free;
         end
         ST_FLUSH: cmd.flush_step = stat.out_free;
         ST_REPLY: cmd.reply_step = stat.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/terminal_id_query_interceptor.sv =====
`timescale 1ns / 1ps
// Identity-query interceptor for a host-bound terminal byte stream.
// Request channel (req_): one stream byte per beat plus a first-of-call flag
// that clears the per-call reply byte count. Response channel (rsp_): one
// emitted byte per beat, flagged pass-through or reply, with last_of_run set
// on the final beat caused by a request byte. Swallowed bytes cause no beat.
// Config channel (csr_): index 0 = profile, index 1 = reply byte budget;
// always ready; the user must write only while idle; the block does not check.
// Flow: a pass-through or swallowed byte is taken without leaving idle, and
// a passed byte appears on rsp_ in the cycle after it is taken. A byte that
// releases held prefix bytes emits them, then itself; in flushes and replies
// the single output register emits one beat per cycle unless stalled.
// A new request is taken while the last beat still waits in the output
// register, as long as the receiver takes it in the same cycle.
// Reset: profile 1, budget 65535, parser back to plain pass-through, prefix
// and reply count cleared, no response beat pending.
// Stall: rsp_ready low holds the beat and, in turn, the request channel.
module terminal_id_query_interceptor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_first_of_call,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_to_response,
   output logic                          rsp_last_of_run,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tqi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_data
);
   import tqi_pkg::*;

   tqi_cmd_type  cmd;
   tqi_stat_type stat;

   assign csr_ready = 1'b1;

   tqi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tqi_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_in_byte       (req_in_byte),
      .req_first_of_call (req_first_of_call),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_to_response   (rsp_to_response),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ===== hdl/tqi_checker.sv =====
`timescale 1ns / 1ps

module tqi_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_to_response,
   input logic       rsp_last_of_run
);
   import tqi_pkg::*;
`include "terminal_id_query_interceptor_assert.svh"

   // A stalled response beat holds
   `TQI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte), "rsp beat changed while stalled")

   // No request is taken while a run is still being emitted
   `TQI_ASSERT_NOW(a_run_blocks_req, rsp_valid && !rsp_last_of_run, !req_ready, "request taken in the middle of a run")

   // Every reply ends in its final character
   `TQI_ASSERT_NOW(a_reply_end, rsp_valid && rsp_to_response && rsp_last_of_run, rsp_out_byte == CH_C || rsp_out_byte == CH_Z, "reply run ends on a wrong byte")

   // Reset leaves no response beat pending
   `TQI_ASSERT_ALWAYS(a_reset_clear, reset, !rsp_valid, "response beat pending after reset")

endmodule

bind terminal_id_query_interceptor tqi_checker u_tqi_checker (.*);
